FILE: hdl/circle_elastic_collision_response_core_defines.svh
// assertion helpers for the collision response core
`ifndef CIRCLE_ELASTIC_COLLISION_RESPONSE_CORE_DEFINES_SVH
`define CIRCLE_ELASTIC_COLLISION_RESPONSE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ECR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ECR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ecr_pkg.sv
package ecr_pkg;

    localparam int VAL_W = 20;
    localparam int RAD_W = 14;
    localparam int MASS_W = 16;

    localparam int ROOT_W = 23;
    localparam int UNIT_QW = 17;
    localparam int UNIT_DW = 23;
    localparam int ELAS_QW = 38;
    localparam int ELAS_DW = 17;

    localparam logic signed [59:0] SAT_HI = 60'sd524287;
    localparam logic signed [59:0] SAT_LO = -60'sd524288;

    typedef logic signed [VAL_W-1:0] coord_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t v1x;
        coord_t v1y;
        coord_t v2x;
        coord_t v2y;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic hit;
        logic coin;
    } base_t;

    function automatic coord_t sat20(input logic signed [59:0] v);
        coord_t r;
        if (v > SAT_HI)
            r = coord_t'(SAT_HI[19:0]);
        else if (v < SAT_LO)
            r = coord_t'(SAT_LO[19:0]);
        else
            r = coord_t'(v[19:0]);
        return r;
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [59:0] rnd_shr(input logic signed [59:0] v,
                                                  input int unsigned s);
        logic [59:0] mag;
        logic [59:0] q;
        mag = v[59] ? 60'(-v) : 60'(v);
        q = (mag + (60'd1 << (s - 1))) >> s;
        return v[59] ? -$signed(q) : $signed(q);
    endfunction

endpackage

FILE: hdl/ecr_channels.sv
interface ecr_req_if import ecr_pkg::*; ();
    logic valid;
    logic ready;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t first_vx;
    coord_t first_vy;
    coord_t second_vx;
    coord_t second_vy;
    logic [RAD_W-1:0] first_radius;
    logic [RAD_W-1:0] second_radius;
    logic [MASS_W-1:0] first_mass;
    logic [MASS_W-1:0] second_mass;

    modport source (
        output valid, first_x, first_y, second_x, second_y,
        output first_vx, first_vy, second_vx, second_vy,
        output first_radius, second_radius, first_mass, second_mass,
        input ready
    );
    modport sink (
        input valid, first_x, first_y, second_x, second_y,
        input first_vx, first_vy, second_vx, second_vy,
        input first_radius, second_radius, first_mass, second_mass,
        output ready
    );
endinterface

interface ecr_rsp_if import ecr_pkg::*; ();
    logic valid;
    logic ready;
    logic collided;
    logic coincident;
    coord_t new_first_x;
    coord_t new_first_y;
    coord_t new_second_x;
    coord_t new_second_y;
    coord_t new_first_vx;
    coord_t new_first_vy;
    coord_t new_second_vx;
    coord_t new_second_vy;

    modport source (
        output valid, collided, coincident,
        output new_first_x, new_first_y, new_second_x, new_second_y,
        output new_first_vx, new_first_vy, new_second_vx, new_second_vy,
        input ready
    );
    modport sink (
        input valid, collided, coincident,
        input new_first_x, new_first_y, new_second_x, new_second_y,
        input new_first_vx, new_first_vy, new_second_vx, new_second_vy,
        output ready
    );
endinterface

FILE: hdl/ecr_sqrt_pipe.sv
module ecr_sqrt_pipe import ecr_pkg::*; #(
    parameter int RW = 23,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*RW-1:0] rad,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [RW-1:0]   root,
    output logic [SW-1:0]   side_out
);

    localparam int CW = RW + 4;

    logic            valid_reg [RW];
    logic [RW+1:0]   rem_reg   [RW];
    logic [RW-1:0]   root_reg  [RW];
    logic [2*RW-1:0] rad_reg   [RW];
    logic [SW-1:0]   side_reg  [RW];

    for (genvar g = 0; g < RW; g++) begin : g_stage
        logic            cur_valid;
        logic [RW+1:0]   cur_rem;
        logic [RW-1:0]   cur_root;
        logic [2*RW-1:0] cur_rad;
        logic [SW-1:0]   cur_side;
        logic [CW-1:0]   cand;
        logic [CW-1:0]   trial;
        logic            fit;

        if (g == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem   = '0;
            assign cur_root  = '0;
            assign cur_rad   = rad;
            assign cur_side  = side_in;
        end
        else begin : g_next
            assign cur_valid = valid_reg[g-1];
            assign cur_rem   = rem_reg[g-1];
            assign cur_root  = root_reg[g-1];
            assign cur_rad   = rad_reg[g-1];
            assign cur_side  = side_reg[g-1];
        end

        assign cand  = {cur_rem, cur_rad[2*RW-1 -: 2]};
        assign trial = CW'({cur_root, 2'b01});
        assign fit   = cand >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= fit ? (RW+2)'(cand - trial) : (RW+2)'(cand);
                root_reg[g] <= {cur_root[RW-2:0], fit};
                rad_reg[g]  <= {cur_rad[2*RW-3:0], 2'b00};
                side_reg[g] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

FILE: hdl/ecr_div_pipe.sv
module ecr_div_pipe import ecr_pkg::*; #(
    parameter int DW = 23,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW+QW-1:0] num_a,
    input  logic [DW+QW-1:0] num_b,
    input  logic [DW-1:0]    den,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [QW-1:0]    quo_a,
    output logic [QW-1:0]    quo_b,
    output logic [SW-1:0]    side_out
);

    localparam int NW = DW + QW;

    logic          valid_reg [QW];
    logic [DW-1:0] rem_a_reg [QW];
    logic [DW-1:0] rem_b_reg [QW];
    logic [QW-1:0] lq_a_reg  [QW];
    logic [QW-1:0] lq_b_reg  [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [SW-1:0] side_reg  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic          cur_valid;
        logic [DW-1:0] cur_rem_a;
        logic [DW-1:0] cur_rem_b;
        logic [QW-1:0] cur_lq_a;
        logic [QW-1:0] cur_lq_b;
        logic [DW-1:0] cur_den;
        logic [SW-1:0] cur_side;
        logic [DW:0]   cand_a;
        logic [DW:0]   cand_b;
        logic          fit_a;
        logic          fit_b;

        if (g == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_rem_a = num_a[NW-1 -: DW];
            assign cur_rem_b = num_b[NW-1 -: DW];
            assign cur_lq_a  = num_a[QW-1:0];
            assign cur_lq_b  = num_b[QW-1:0];
            assign cur_den   = den;
            assign cur_side  = side_in;
        end
        else begin : g_next
            assign cur_valid = valid_reg[g-1];
            assign cur_rem_a = rem_a_reg[g-1];
            assign cur_rem_b = rem_b_reg[g-1];
            assign cur_lq_a  = lq_a_reg[g-1];
            assign cur_lq_b  = lq_b_reg[g-1];
            assign cur_den   = den_reg[g-1];
            assign cur_side  = side_reg[g-1];
        end

        assign cand_a = {cur_rem_a, cur_lq_a[QW-1]};
        assign cand_b = {cur_rem_b, cur_lq_b[QW-1]};
        assign fit_a  = cand_a >= {1'b0, cur_den};
        assign fit_b  = cand_b >= {1'b0, cur_den};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[g] <= 1'b0;
            else if (en)
                valid_reg[g] <= cur_valid;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[g] <= fit_a ? DW'(cand_a - {1'b0, cur_den}) : DW'(cand_a);
                rem_b_reg[g] <= fit_b ? DW'(cand_b - {1'b0, cur_den}) : DW'(cand_b);
                lq_a_reg[g]  <= {cur_lq_a[QW-2:0], fit_a};
                lq_b_reg[g]  <= {cur_lq_b[QW-2:0], fit_b};
                den_reg[g]   <= cur_den;
                side_reg[g]  <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo_a     = lq_a_reg[QW-1];
    assign quo_b     = lq_b_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: hdl/circle_elastic_collision_response_core.sv
// throughput: one request per cycle; the whole pipeline holds while a result waits
// depth is set by the 23-step square root and the 17- and 38-step dividers
// reset: asynchronous active low, clears every stage valid bit; no result pending
`include "circle_elastic_collision_response_core_defines.svh"

module circle_elastic_collision_response_core import ecr_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    ecr_req_if.sink    pair,
    ecr_rsp_if.source  result
);

    typedef struct packed {
        base_t base;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic [14:0] rs;
    } s1_t;

    typedef struct packed {
        base_t base;
        logic signed [20:0] dx;
        logic signed [20:0] dy;
        logic [14:0] rs;
        logic [41:0] dx2;
        logic [41:0] dy2;
        logic [29:0] rs2;
    } s2_t;

    typedef struct packed {
        base_t base;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [14:0] rs;
    } sq_side_t;

    typedef struct packed {
        base_t base;
        logic sa;
        logic sb;
        logic [23:0] over;
    } d1_side_t;

    typedef struct packed {
        base_t base;
        logic [23:0] over;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
    } s5_t;

    typedef struct packed {
        base_t base;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [37:0] p11;
        logic signed [37:0] p12;
        logic signed [37:0] p13;
        logic signed [37:0] p14;
        logic signed [37:0] p21;
        logic signed [37:0] p22;
        logic signed [37:0] p23;
        logic signed [37:0] p24;
        logic signed [42:0] pox;
        logic signed [42:0] poy;
    } s6_t;

    typedef struct packed {
        base_t base;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [38:0] v1n;
        logic signed [38:0] v1t;
        logic signed [38:0] v2n;
        logic signed [38:0] v2t;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [16:0] dm;
        logic [15:0] m1e;
        logic [15:0] m2e;
        logic [16:0] ms;
    } s7_t;

    typedef struct packed {
        base_t base;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [38:0] v1t;
        logic signed [38:0] v2t;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [16:0] ms;
        logic signed [55:0] a1;
        logic signed [55:0] b1;
        logic signed [55:0] a2;
        logic signed [55:0] b2;
    } s8_t;

    typedef struct packed {
        base_t base;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [38:0] v1t;
        logic signed [38:0] v2t;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [16:0] ms;
        logic signed [57:0] n1;
        logic signed [57:0] n2;
    } s9_t;

    typedef struct packed {
        base_t base;
        logic s1;
        logic s2;
        logic signed [38:0] v1t;
        logic signed [38:0] v2t;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } d2_side_t;

    typedef struct packed {
        base_t base;
        logic signed [17:0] ux;
        logic signed [17:0] uy;
        logic signed [38:0] v1t;
        logic signed [38:0] v2t;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [38:0] v1p;
        logic signed [38:0] v2p;
    } s11_t;

    typedef struct packed {
        base_t base;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [56:0] q11;
        logic signed [56:0] q12;
        logic signed [56:0] q13;
        logic signed [56:0] q14;
        logic signed [56:0] q21;
        logic signed [56:0] q22;
        logic signed [56:0] q23;
        logic signed [56:0] q24;
    } s12_t;

    typedef struct packed {
        base_t base;
        logic signed [57:0] e1x;
        logic signed [57:0] e1y;
        logic signed [57:0] e2x;
        logic signed [57:0] e2y;
        logic signed [20:0] nx1;
        logic signed [20:0] ny1;
        logic signed [20:0] nx2;
        logic signed [20:0] ny2;
    } s13_t;

    typedef struct packed {
        logic collided;
        logic coincident;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t v1x;
        coord_t v1y;
        coord_t v2x;
        coord_t v2y;
    } res_t;

    logic adv;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, s9_valid_reg, s10_valid_reg;
    logic s11_valid_reg, s12_valid_reg, s13_valid_reg, s14_valid_reg;

    s1_t      s1_reg, s1_next;
    s2_t      s2_reg, s2_next;
    sq_side_t s3_reg, s3_next;
    logic [29:0] s3_rad_reg, s3_rad_next;

    logic        sq_valid;
    logic [22:0] sq_root;
    sq_side_t    sq_side;

    d1_side_t s4_reg, s4_next;
    logic [39:0] s4_na_reg, s4_na_next, s4_nb_reg, s4_nb_next;
    logic [22:0] s4_den_reg;

    logic        d1_valid;
    logic [16:0] d1_qa, d1_qb;
    d1_side_t    d1_side;

    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;
    s7_t  s7_reg, s7_next;
    s8_t  s8_reg, s8_next;
    s9_t  s9_reg, s9_next;

    d2_side_t s10_reg, s10_next;
    logic [54:0] s10_na_reg, s10_na_next, s10_nb_reg, s10_nb_next;
    logic [16:0] s10_den_reg;

    logic        d2_valid;
    logic [37:0] d2_qa, d2_qb;
    d2_side_t    d2_side;

    s11_t s11_reg, s11_next;
    s12_t s12_reg, s12_next;
    s13_t s13_reg, s13_next;
    res_t s14_reg, s14_next;

    logic [15:0] dxm, dym;
    logic [15:0] m1e, m2e;
    logic [57:0] half, mag1, mag2;

    assign adv        = !s14_valid_reg || result.ready;
    assign pair.ready = adv;

    // stage 1: differences and radius sum
    always_comb
    begin
        s1_next.base.x1   = pair.first_x;
        s1_next.base.y1   = pair.first_y;
        s1_next.base.x2   = pair.second_x;
        s1_next.base.y2   = pair.second_y;
        s1_next.base.v1x  = pair.first_vx;
        s1_next.base.v1y  = pair.first_vy;
        s1_next.base.v2x  = pair.second_vx;
        s1_next.base.v2y  = pair.second_vy;
        s1_next.base.m1   = pair.first_mass;
        s1_next.base.m2   = pair.second_mass;
        s1_next.base.hit  = 1'b0;
        s1_next.base.coin = 1'b0;
        s1_next.dx = 21'(pair.first_x) - 21'(pair.second_x);
        s1_next.dy = 21'(pair.first_y) - 21'(pair.second_y);
        s1_next.rs = 15'(pair.first_radius) + 15'(pair.second_radius);
    end

    // stage 2: squares
    always_comb
    begin
        s2_next.base = s1_reg.base;
        s2_next.dx   = s1_reg.dx;
        s2_next.dy   = s1_reg.dy;
        s2_next.rs   = s1_reg.rs;
        s2_next.dx2  = s1_reg.dx * s1_reg.dx;
        s2_next.dy2  = s1_reg.dy * s1_reg.dy;
        s2_next.rs2  = s1_reg.rs * s1_reg.rs;
    end

    // stage 3: contact test
    always_comb
    begin
        logic [41:0] d2;
        d2 = s2_reg.dx2 + s2_reg.dy2;
        s3_next.base      = s2_reg.base;
        s3_next.base.coin = (s2_reg.dx == '0) && (s2_reg.dy == '0);
        s3_next.base.hit  = !s3_next.base.coin && (d2 <= 42'(s2_reg.rs2));
        s3_next.dx        = s2_reg.dx[15:0];
        s3_next.dy        = s2_reg.dy[15:0];
        s3_next.rs        = s2_reg.rs;
        s3_rad_next       = d2[29:0];
    end

    ecr_sqrt_pipe #(
        .RW (ROOT_W),
        .SW ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s3_valid_reg),
        .rad       ({s3_rad_reg, 16'd0}),
        .side_in   (s3_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // stage 4: unit normal numerators, overlap
    always_comb
    begin
        dxm = sq_side.dx[15] ? 16'(-sq_side.dx) : 16'(sq_side.dx);
        dym = sq_side.dy[15] ? 16'(-sq_side.dy) : 16'(sq_side.dy);
        s4_na_next   = 40'({dxm[14:0], 24'd0}) + 40'(sq_root[22:1]);
        s4_nb_next   = 40'({dym[14:0], 24'd0}) + 40'(sq_root[22:1]);
        s4_next.base = sq_side.base;
        s4_next.sa   = sq_side.dx[15];
        s4_next.sb   = sq_side.dy[15];
        s4_next.over = 24'({sq_side.rs, 8'd0}) - 24'(sq_root);
    end

    ecr_div_pipe #(
        .DW (UNIT_DW),
        .QW (UNIT_QW),
        .SW ($bits(d1_side_t))
    ) u_unit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_valid_reg),
        .num_a     (s4_na_reg),
        .num_b     (s4_nb_reg),
        .den       (s4_den_reg),
        .side_in   (s4_reg),
        .out_valid (d1_valid),
        .quo_a     (d1_qa),
        .quo_b     (d1_qb),
        .side_out  (d1_side)
    );

    // stage 5: signed unit normal
    always_comb
    begin
        s5_next.base = d1_side.base;
        s5_next.over = d1_side.over;
        s5_next.ux   = d1_side.sa ? -$signed(18'(d1_qa)) : $signed(18'(d1_qa));
        s5_next.uy   = d1_side.sb ? -$signed(18'(d1_qb)) : $signed(18'(d1_qb));
    end

    // stage 6: projections onto normal and tangent
    always_comb
    begin
        s6_next.base = s5_reg.base;
        s6_next.ux   = s5_reg.ux;
        s6_next.uy   = s5_reg.uy;
        s6_next.p11  = s5_reg.base.v1x * s5_reg.ux;
        s6_next.p12  = s5_reg.base.v1y * s5_reg.uy;
        s6_next.p13  = s5_reg.base.v1x * s5_reg.uy;
        s6_next.p14  = s5_reg.base.v1y * s5_reg.ux;
        s6_next.p21  = s5_reg.base.v2x * s5_reg.ux;
        s6_next.p22  = s5_reg.base.v2y * s5_reg.uy;
        s6_next.p23  = s5_reg.base.v2x * s5_reg.uy;
        s6_next.p24  = s5_reg.base.v2y * s5_reg.ux;
        s6_next.pox  = $signed({1'b0, s5_reg.over}) * s5_reg.ux;
        s6_next.poy  = $signed({1'b0, s5_reg.over}) * s5_reg.uy;
    end

    // stage 7: normal and tangential speeds, push, masses
    always_comb
    begin
        logic signed [59:0] rx;
        logic signed [59:0] ry;
        rx = rnd_shr(60'(s6_reg.pox), 25);
        ry = rnd_shr(60'(s6_reg.poy), 25);
        if (s6_reg.base.m1 == '0 && s6_reg.base.m2 == '0)
        begin
            m1e = 16'd1;
            m2e = 16'd1;
        end
        else
        begin
            m1e = s6_reg.base.m1;
            m2e = s6_reg.base.m2;
        end
        s7_next.base = s6_reg.base;
        s7_next.ux   = s6_reg.ux;
        s7_next.uy   = s6_reg.uy;
        s7_next.v1n  = 39'(s6_reg.p11) + 39'(s6_reg.p12);
        s7_next.v1t  = 39'(s6_reg.p14) - 39'(s6_reg.p13);
        s7_next.v2n  = 39'(s6_reg.p21) + 39'(s6_reg.p22);
        s7_next.v2t  = 39'(s6_reg.p24) - 39'(s6_reg.p23);
        s7_next.px   = rx[15:0];
        s7_next.py   = ry[15:0];
        s7_next.dm   = $signed({1'b0, m1e}) - $signed({1'b0, m2e});
        s7_next.m1e  = m1e;
        s7_next.m2e  = m2e;
        s7_next.ms   = 17'(m1e) + 17'(m2e);
    end

    // stage 8: momentum products
    always_comb
    begin
        s8_next.base = s7_reg.base;
        s8_next.ux   = s7_reg.ux;
        s8_next.uy   = s7_reg.uy;
        s8_next.v1t  = s7_reg.v1t;
        s8_next.v2t  = s7_reg.v2t;
        s8_next.px   = s7_reg.px;
        s8_next.py   = s7_reg.py;
        s8_next.ms   = s7_reg.ms;
        s8_next.a1   = s7_reg.v1n * s7_reg.dm;
        s8_next.b1   = s7_reg.v2n * $signed({1'b0, s7_reg.m2e});
        s8_next.a2   = s7_reg.v2n * s7_reg.dm;
        s8_next.b2   = s7_reg.v1n * $signed({1'b0, s7_reg.m1e});
    end

    // stage 9: elastic numerators
    always_comb
    begin
        s9_next.base = s8_reg.base;
        s9_next.ux   = s8_reg.ux;
        s9_next.uy   = s8_reg.uy;
        s9_next.v1t  = s8_reg.v1t;
        s9_next.v2t  = s8_reg.v2t;
        s9_next.px   = s8_reg.px;
        s9_next.py   = s8_reg.py;
        s9_next.ms   = s8_reg.ms;
        s9_next.n1   = 58'(s8_reg.a1) + (58'(s8_reg.b1) <<< 1);
        s9_next.n2   = (58'(s8_reg.b2) <<< 1) - 58'(s8_reg.a2);
    end

    // stage 10: magnitudes with rounding offset
    always_comb
    begin
        half = 58'(s9_reg.ms[16:1]);
        mag1 = s9_reg.n1[57] ? half - 58'(s9_reg.n1) : 58'(s9_reg.n1) + half;
        mag2 = s9_reg.n2[57] ? half - 58'(s9_reg.n2) : 58'(s9_reg.n2) + half;
        s10_na_next   = mag1[54:0];
        s10_nb_next   = mag2[54:0];
        s10_next.base = s9_reg.base;
        s10_next.s1   = s9_reg.n1[57];
        s10_next.s2   = s9_reg.n2[57];
        s10_next.v1t  = s9_reg.v1t;
        s10_next.v2t  = s9_reg.v2t;
        s10_next.ux   = s9_reg.ux;
        s10_next.uy   = s9_reg.uy;
        s10_next.px   = s9_reg.px;
        s10_next.py   = s9_reg.py;
    end

    ecr_div_pipe #(
        .DW (ELAS_DW),
        .QW (ELAS_QW),
        .SW ($bits(d2_side_t))
    ) u_elastic_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s10_valid_reg),
        .num_a     (s10_na_reg),
        .num_b     (s10_nb_reg),
        .den       (s10_den_reg),
        .side_in   (s10_reg),
        .out_valid (d2_valid),
        .quo_a     (d2_qa),
        .quo_b     (d2_qb),
        .side_out  (d2_side)
    );

    // stage 11: signed normal speeds after exchange
    always_comb
    begin
        s11_next.base = d2_side.base;
        s11_next.ux   = d2_side.ux;
        s11_next.uy   = d2_side.uy;
        s11_next.v1t  = d2_side.v1t;
        s11_next.v2t  = d2_side.v2t;
        s11_next.px   = d2_side.px;
        s11_next.py   = d2_side.py;
        s11_next.v1p  = d2_side.s1 ? -$signed(39'(d2_qa)) : $signed(39'(d2_qa));
        s11_next.v2p  = d2_side.s2 ? -$signed(39'(d2_qb)) : $signed(39'(d2_qb));
    end

    // stage 12: back to x and y
    always_comb
    begin
        s12_next.base = s11_reg.base;
        s12_next.px   = s11_reg.px;
        s12_next.py   = s11_reg.py;
        s12_next.q11  = s11_reg.v1p * s11_reg.ux;
        s12_next.q12  = s11_reg.v1t * s11_reg.uy;
        s12_next.q13  = s11_reg.v1p * s11_reg.uy;
        s12_next.q14  = s11_reg.v1t * s11_reg.ux;
        s12_next.q21  = s11_reg.v2p * s11_reg.ux;
        s12_next.q22  = s11_reg.v2t * s11_reg.uy;
        s12_next.q23  = s11_reg.v2p * s11_reg.uy;
        s12_next.q24  = s11_reg.v2t * s11_reg.ux;
    end

    // stage 13: velocity sums, pushed centres
    always_comb
    begin
        s13_next.base = s12_reg.base;
        s13_next.e1x  = 58'(s12_reg.q11) - 58'(s12_reg.q12);
        s13_next.e1y  = 58'(s12_reg.q13) + 58'(s12_reg.q14);
        s13_next.e2x  = 58'(s12_reg.q21) - 58'(s12_reg.q22);
        s13_next.e2y  = 58'(s12_reg.q23) + 58'(s12_reg.q24);
        s13_next.nx1  = 21'(s12_reg.base.x1) + 21'(s12_reg.px);
        s13_next.ny1  = 21'(s12_reg.base.y1) + 21'(s12_reg.py);
        s13_next.nx2  = 21'(s12_reg.base.x2) - 21'(s12_reg.px);
        s13_next.ny2  = 21'(s12_reg.base.y2) - 21'(s12_reg.py);
    end

    // stage 14: rounding and saturation on contact, output register
    always_comb
    begin
        s14_next.collided   = s13_reg.base.hit;
        s14_next.coincident = s13_reg.base.coin;
        if (s13_reg.base.hit)
        begin
            s14_next.x1  = sat20(60'(s13_reg.nx1));
            s14_next.y1  = sat20(60'(s13_reg.ny1));
            s14_next.x2  = sat20(60'(s13_reg.nx2));
            s14_next.y2  = sat20(60'(s13_reg.ny2));
            s14_next.v1x = sat20(rnd_shr(60'(s13_reg.e1x), 32));
            s14_next.v1y = sat20(rnd_shr(60'(s13_reg.e1y), 32));
            s14_next.v2x = sat20(rnd_shr(60'(s13_reg.e2x), 32));
            s14_next.v2y = sat20(rnd_shr(60'(s13_reg.e2y), 32));
        end
        else
        begin
            s14_next.x1  = s13_reg.base.x1;
            s14_next.y1  = s13_reg.base.y1;
            s14_next.x2  = s13_reg.base.x2;
            s14_next.y2  = s13_reg.base.y2;
            s14_next.v1x = s13_reg.base.v1x;
            s14_next.v1y = s13_reg.base.v1y;
            s14_next.v2x = s13_reg.base.v2x;
            s14_next.v2y = s13_reg.base.v2y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
            s11_valid_reg <= 1'b0;
            s12_valid_reg <= 1'b0;
            s13_valid_reg <= 1'b0;
            s14_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pair.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= sq_valid;
            s5_valid_reg  <= d1_valid;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            s9_valid_reg  <= s8_valid_reg;
            s10_valid_reg <= s9_valid_reg;
            s11_valid_reg <= d2_valid;
            s12_valid_reg <= s11_valid_reg;
            s13_valid_reg <= s12_valid_reg;
            s14_valid_reg <= s13_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s3_rad_reg  <= s3_rad_next;
            s4_reg      <= s4_next;
            s4_na_reg   <= s4_na_next;
            s4_nb_reg   <= s4_nb_next;
            s4_den_reg  <= sq_root;
            s5_reg      <= s5_next;
            s6_reg      <= s6_next;
            s7_reg      <= s7_next;
            s8_reg      <= s8_next;
            s9_reg      <= s9_next;
            s10_reg     <= s10_next;
            s10_na_reg  <= s10_na_next;
            s10_nb_reg  <= s10_nb_next;
            s10_den_reg <= s9_reg.ms;
            s11_reg     <= s11_next;
            s12_reg     <= s12_next;
            s13_reg     <= s13_next;
            s14_reg     <= s14_next;
        end
    end

    assign result.valid         = s14_valid_reg;
    assign result.collided      = s14_reg.collided;
    assign result.coincident    = s14_reg.coincident;
    assign result.new_first_x   = s14_reg.x1;
    assign result.new_first_y   = s14_reg.y1;
    assign result.new_second_x  = s14_reg.x2;
    assign result.new_second_y  = s14_reg.y2;
    assign result.new_first_vx  = s14_reg.v1x;
    assign result.new_first_vy  = s14_reg.v1y;
    assign result.new_second_vx = s14_reg.v2x;
    assign result.new_second_vy = s14_reg.v2y;

    `ECR_ASSERT_NOW(a_flags_exclusive, result.valid, !(result.collided && result.coincident), "collided and coincident both set")
    `ECR_ASSERT_NOW(a_stall_blocks_request, result.valid && !result.ready, !pair.ready, "request taken while result stalled")
    `ECR_ASSERT_NEXT(a_miss_keeps_velocity, adv && s13_valid_reg && !s13_reg.base.hit, result.new_first_vx == $past(s13_reg.base.v1x), "velocity changed without contact")

endmodule
